// File: rtl/decimal_seven_segment_driver_top_assert.svh
// Assertion macros for the checker file of the seven-segment driver.
`ifndef DECIMAL_SEVEN_SEGMENT_DRIVER_TOP_ASSERT_SVH
`define DECIMAL_SEVEN_SEGMENT_DRIVER_TOP_ASSERT_SVH

// Checked on every clock edge outside reset.
`define DSSD_ASSERT(label, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("dssd check failed");

// Checked on every clock edge, reset included.
`define DSSD_ASSERT_RST(label, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("dssd reset check failed");

`endif

// File: rtl/dssd_pkg.sv
package dssd_pkg;

  // number of digit fields on the result word
  localparam int FIELD_COUNT = 6;
  localparam int DIGIT_W     = 4;
  localparam int SEG_W       = 8;

  localparam logic [SEG_W-1:0] BLANK = 8'hff;

  // x / 10 == (x * 0xCCCCCCCD) >> 35 for any 32-bit x
  localparam int              RECIP_W     = 32;
  localparam logic [RECIP_W-1:0] RECIP    = 32'hCCCC_CCCD;
  localparam int              RECIP_SHIFT = 35;

  typedef enum logic {
    CMD_INTEGER = 1'b0,
    CMD_TIME    = 1'b1
  } cmd_t;

  // side data that travels down the cell chain with the quotient
  typedef struct packed {
    cmd_t                                  cmd;
    logic [FIELD_COUNT-1:0][DIGIT_W-1:0]   digits;  // decimal digit i of value
    logic [FIELD_COUNT-1:0]                nz;      // value / 10**i != 0
  } cell_ctl_t;

  // active-low segment pattern of one decimal digit
  function automatic logic [SEG_W-1:0] seg_code(input logic [DIGIT_W-1:0] d);
    logic [SEG_W-1:0] code;
    case (d)
      4'd0:    code = 8'h40;
      4'd1:    code = 8'h79;
      4'd2:    code = 8'h24;
      4'd3:    code = 8'h30;
      4'd4:    code = 8'h19;
      4'd5:    code = 8'h12;
      4'd6:    code = 8'h02;
      4'd7:    code = 8'h78;
      4'd8:    code = 8'h00;
      4'd9:    code = 8'h10;
      default: code = BLANK;
    endcase
    return code;
  endfunction

endpackage

// File: rtl/decimal_seven_segment_driver_top.sv
// Decimal seven-segment driver.
//
// Input channel (item_valid/item_ready): one word carries cmd and value.
//   cmd = 0 shows value as a decimal integer on six digits, leading zeros
//   blanked; cmd = 1 reads value as milliseconds and shows seconds on
//   digits 5..4 (tens digit only from ten seconds on), a blank digit 3 and
//   the milliseconds with leading zeros on digits 2..0.
// Output channel (result_valid/result_ready): one word of six active-low
//   segment patterns, digit0 the least significant, 0xff for blank.
// A chain of six cells each takes one divide-by-ten step (reciprocal
//   multiply) and records one decimal digit; a formatting and output stage
//   with a one-word skid register follows.
// A word passes through the six cell registers and then the output register
//   before it is offered. Throughput: one word per cycle while the output is not stalled.
// Stall: while result_ready is low the output word holds; the skid takes one
//   more word, then item_ready drops and the whole chain freezes. item_ready
//   comes from a register only (skid empty).
// Reset (rst, synchronous): all valid flags clear, the chain is empty and
//   item_ready is high from the first cycle after reset.
module decimal_seven_segment_driver_top #(
  parameter int DIGIT_COUNT = 6,
  parameter int VALUE_WIDTH = 20
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   item_valid,
  output logic                   item_ready,
  input  logic                   cmd,
  input  logic [VALUE_WIDTH-1:0] value,
  output logic                   result_valid,
  input  logic                   result_ready,
  output logic [7:0]             digit0,
  output logic [7:0]             digit1,
  output logic [7:0]             digit2,
  output logic [7:0]             digit3,
  output logic [7:0]             digit4,
  output logic [7:0]             digit5
);
  import dssd_pkg::*;

  logic                              en;
  logic [FIELD_COUNT:0]              vld_chain;
  cell_ctl_t                         ctl_chain [FIELD_COUNT+1];
  logic [VALUE_WIDTH-1:0]            q_chain   [FIELD_COUNT+1];
  logic [FIELD_COUNT-1:0][SEG_W-1:0] res_data;

  assign item_ready = en;

  // head of the chain: the raw word, no digits yet
  assign vld_chain[0]         = item_valid;
  assign q_chain[0]           = value;
  assign ctl_chain[0].cmd     = cmd_t'(cmd);
  assign ctl_chain[0].digits  = '0;
  assign ctl_chain[0].nz      = '0;

  for (genvar g = 0; g < FIELD_COUNT; g++) begin : g_cell
    dssd_cell #(
      .IDX (g),
      .VW  (VALUE_WIDTH)
    ) u_cell (
      .clk        (clk),
      .rst        (rst),
      .en         (en),
      .valid_prev (vld_chain[g]),
      .ctl_prev   (ctl_chain[g]),
      .q_prev     (q_chain[g]),
      .valid      (vld_chain[g+1]),
      .ctl        (ctl_chain[g+1]),
      .q          (q_chain[g+1])
    );
  end

  dssd_out #(
    .DIGIT_COUNT (DIGIT_COUNT)
  ) u_out (
    .clk        (clk),
    .rst        (rst),
    .last_valid (vld_chain[FIELD_COUNT]),
    .ctl        (ctl_chain[FIELD_COUNT]),
    .en         (en),
    .res_valid  (result_valid),
    .res_ready  (result_ready),
    .res_data   (res_data)
  );

  assign digit0 = res_data[0];
  assign digit1 = res_data[1];
  assign digit2 = res_data[2];
  assign digit3 = res_data[3];
  assign digit4 = res_data[4];
  assign digit5 = res_data[5];

endmodule

// File: rtl/dssd_cell.sv
module dssd_cell #(
  parameter int IDX = 0,
  parameter int VW  = 20
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                en,
  input  logic                valid_prev,
  input  dssd_pkg::cell_ctl_t ctl_prev,
  input  logic [VW-1:0]       q_prev,
  output logic                valid,
  output dssd_pkg::cell_ctl_t ctl,
  output logic [VW-1:0]       q
);
  import dssd_pkg::*;

  logic [RECIP_W-1:0]   q_ext;
  logic [2*RECIP_W-1:0] prod;
  logic [VW-1:0]        quot;
  logic [VW-1:0]        rem_full;
  cell_ctl_t            ctl_next;

  // one divide-by-ten step: quotient moves on, remainder is digit IDX
  always_comb begin
    q_ext    = RECIP_W'(q_prev);
    prod     = (2*RECIP_W)'(q_ext) * (2*RECIP_W)'(RECIP);
    quot     = VW'(prod >> RECIP_SHIFT);
    rem_full = q_prev - ((quot << 3) + (quot << 1));
    ctl_next              = ctl_prev;
    ctl_next.digits[IDX]  = DIGIT_W'(rem_full);
    ctl_next.nz[IDX]      = (q_prev != '0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (en) begin
      valid <= valid_prev;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ctl <= ctl_next;
      q   <= quot;
    end
  end

endmodule

// File: rtl/dssd_out.sv
module dssd_out #(
  parameter int DIGIT_COUNT = 6
) (
  input  logic                                              clk,
  input  logic                                              rst,
  input  logic                                              last_valid,
  input  dssd_pkg::cell_ctl_t                               ctl,
  output logic                                              en,
  output logic                                              res_valid,
  input  logic                                              res_ready,
  output logic [dssd_pkg::FIELD_COUNT-1:0][dssd_pkg::SEG_W-1:0] res_data
);
  import dssd_pkg::*;

  logic [FIELD_COUNT-1:0][SEG_W-1:0] fmt;
  logic [FIELD_COUNT-1:0][SEG_W-1:0] skid_data;
  logic                              skid_valid;
  logic                              push;
  logic                              take;

  assign en   = !skid_valid;
  assign push = en && last_valid;
  assign take = !res_valid || res_ready;

  // map chain digits onto display positions
  always_comb begin
    fmt = {FIELD_COUNT{BLANK}};
    case (ctl.cmd)
      CMD_TIME: begin
        fmt[0] = seg_code(ctl.digits[0]);
        fmt[1] = seg_code(ctl.digits[1]);
        fmt[2] = seg_code(ctl.digits[2]);
        fmt[3] = BLANK;
        fmt[4] = seg_code(ctl.digits[3]);
        fmt[5] = ctl.nz[4] ? seg_code(ctl.digits[4]) : BLANK;
      end
      CMD_INTEGER: begin
        for (int i = 0; i < FIELD_COUNT; i++) begin
          fmt[i] = ((i == 0) || ctl.nz[i]) ? seg_code(ctl.digits[i]) : BLANK;
        end
      end
      default: begin
        fmt = {FIELD_COUNT{BLANK}};
      end
    endcase
    for (int i = 0; i < FIELD_COUNT; i++) begin
      if (i >= DIGIT_COUNT) begin
        fmt[i] = BLANK;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else begin
      if (take) begin
        res_valid <= skid_valid || push;
      end
      if (skid_valid) begin
        if (res_ready) begin
          skid_valid <= 1'b0;
        end
      end else if (push && !take) begin
        skid_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      res_data <= skid_valid ? skid_data : fmt;
    end
    if (!skid_valid && push && !take) begin
      skid_data <= fmt;
    end
  end

endmodule

// File: rtl/dssd_checker.sv
`include "decimal_seven_segment_driver_top_assert.svh"

module dssd_checker (
  input logic       clk,
  input logic       rst,
  input logic       result_valid,
  input logic       result_ready,
  input logic [7:0] digit0,
  input logic [7:0] digit1,
  input logic [7:0] digit2,
  input logic [7:0] digit5
);
  import dssd_pkg::*;

  logic [15:0] outer_pair;

  assign outer_pair = {digit5, digit0};

  // nothing left on the output after reset
  `DSSD_ASSERT_RST(a_reset_empty, rst |=> !result_valid)

  // a stalled word stays valid and its outer digits (5 and 0) stay put
  `DSSD_ASSERT(a_stall_hold, result_valid && !result_ready |=> result_valid && $stable(outer_pair))

  // the lowest digit is never blanked
  `DSSD_ASSERT(a_digit0_lit, result_valid |-> digit0 != BLANK)

  // a blank digit one implies a blank digit two
  `DSSD_ASSERT(a_blank_run, result_valid && digit1 == BLANK |-> digit2 == BLANK)

endmodule

bind decimal_seven_segment_driver_top dssd_checker u_dssd_checker (.*);
